/* sv/gsa_pkg.sv */
// Shared opcodes, field widths and inter-module control structs for the slot allocator.
`default_nettype none
package gsa_pkg;

  localparam int OPCODE_W = 2;
  localparam int IDX_W    = 8;
  localparam int GEN_W    = 32;
  localparam int PAY_W    = 32;

  localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd3;

  // slot table port strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctrl_t;

  // free stack commands, at most one of push/pop/clear per cycle
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctrl_t;

endpackage
`default_nettype wire

/* sv/gsa_slot_table.sv */
// Slot table memory {generation, payload} with registered read and last-write bypass.
`default_nettype none
module gsa_slot_table
  import gsa_pkg::*;
#(
  parameter int SLOTS = 256,
  parameter int DW    = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire tbl_ctrl_t                ctrl,
  input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
  input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
  input  wire logic [DW-1:0]            wr_data,
  output logic      [DW-1:0]            rd_data
);

  localparam int IW = $clog2(SLOTS);

  logic [DW-1:0] mem [SLOTS];
  logic [DW-1:0] rd_q;
  logic [IW-1:0] rd_addr_q;
  logic          lw_valid;
  logic [IW-1:0] lw_addr;
  logic [DW-1:0] lw_data;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // a write on the same edge as the read is not seen by rd_q; the latest write wins
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (ctrl.wr_en) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      lw_addr <= wr_addr;
      lw_data <= wr_data;
    end
  end

  assign rd_data = (lw_valid && (lw_addr == rd_addr_q)) ? lw_data : rd_q;

endmodule
`default_nettype wire

/* sv/gsa_free_stack.sv */
// LIFO of freed slots {generation, index} with the top entry held in a register.
`default_nettype none
module gsa_free_stack
  import gsa_pkg::*;
#(
  parameter int SLOTS = 256,
  parameter int EW    = 40
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire stk_ctrl_t                  ctrl,
  input  wire logic [EW-1:0]              push_entry,
  output logic      [$clog2(SLOTS+1)-1:0] count,
  output logic      [EW-1:0]              top
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [EW-1:0] mem [SLOTS];
  logic [CW-1:0] below;

  // entry under the current top becomes the new top on a pop
  assign below = count - CW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.push) begin
      count <= count + CW'(1);
    end else if (ctrl.pop) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[count[IW-1:0]] <= push_entry;
      top                <= push_entry;
    end else if (ctrl.pop) begin
      top <= mem[below[IW-1:0]];
    end
  end

endmodule
`default_nettype wire

/* sv/generational_slot_allocator_core.sv */
// Top level of the generational slot allocator: execute stage, counters and result register.
`default_nettype none
// Handle table with per-slot generation counters. Each transaction on the s_ side carries
// one operation (add, remove, lookup, clear all) and produces exactly one result transaction
// on the m_ side. Add reuses the most recently freed slot and bumps its generation, or
// appends a fresh slot with generation 0, stores the nonzero payload and returns the handle;
// table_full is set when nothing is left. Remove ignores the handle generation and any index
// not yet appended. Lookup is valid only for an occupied slot with a matching generation.
// Throughput is one transaction per cycle while the output side is not stalled by m_tready;
// the slot table read is registered on the accept edge, and the execute stage then updates
// the table, the free stack and the counters and loads the output register when it advances.
// Back-to-back accesses to the same slot are covered by a last-write bypass in front of the
// table read port. The free stack keeps its top entry in a register and prefetches the
// next one on a pop, so pops and pushes run every cycle. No clearing pass: reset and clear
// only zero the fill counts, and every table or stack read is bounded by them. The output
// register holds a finished result while the next transaction is already taken into the
// execute stage.
module generational_slot_allocator_core
  import gsa_pkg::*;
#(
  parameter int SLOTS        = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // opcode[1:0], slot_index[9:2], handle_gen_in[41:10], payload_in[73:42], zero[79:74]
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // handle_index[7:0], handle_generation[39:8], is_valid[40], payload_out[72:41],
  // table_full[73], zero[79:74]
  output logic      [79:0] m_tdata
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = (IW > IDX_W) ? IW : IDX_W;
  localparam int PW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;  // bits that survive
  localparam int DW = GEN_W + PW;   // table word {generation, payload}
  localparam int EW = GEN_W + IW;   // stack entry {generation, index}

  // input field split
  logic [OPCODE_W-1:0] in_op;
  logic [IDX_W-1:0]    in_idx;
  logic [XW-1:0]       in_idx_x;

  assign in_op    = s_tdata[1:0];
  assign in_idx   = s_tdata[9:2];
  assign in_idx_x = XW'(in_idx);

  // execute stage registers
  logic                ex_valid;
  logic [OPCODE_W-1:0] ex_op;
  logic [IDX_W-1:0]    ex_idx;
  logic [IW-1:0]       ex_addr;
  logic [GEN_W-1:0]    ex_gen;
  logic [PW-1:0]       ex_pay;

  logic [CW-1:0] used_count;
  logic [CW-1:0] used_count_next;

  // output register
  logic             out_valid;
  logic [IDX_W-1:0] out_index;
  logic [GEN_W-1:0] out_gen;
  logic             out_ok;
  logic [PAY_W-1:0] out_payload;
  logic             out_full;

  logic advance;
  logic accept;

  assign advance  = ex_valid && (!out_valid || m_tready);
  assign s_tready = !ex_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // submodule hookup
  tbl_ctrl_t     tbl_ctrl;
  logic [IW-1:0] tbl_wr_addr;
  logic [DW-1:0] tbl_wr_data;
  logic [DW-1:0] tbl_rd_data;
  stk_ctrl_t     stk_ctrl;
  logic [EW-1:0] stk_push_entry;
  logic [CW-1:0] free_count;
  logic [EW-1:0] stk_top;

  gsa_slot_table #(
    .SLOTS (SLOTS),
    .DW    (DW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (tbl_ctrl),
    .rd_addr (in_idx_x[IW-1:0]),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_data (tbl_rd_data)
  );

  gsa_free_stack #(
    .SLOTS (SLOTS),
    .EW    (EW)
  ) u_stack (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (stk_ctrl),
    .push_entry (stk_push_entry),
    .count      (free_count),
    .top        (stk_top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (accept) begin
      ex_valid <= 1'b1;
    end else if (advance) begin
      ex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_op   <= in_op;
      ex_idx  <= in_idx;
      ex_addr <= in_idx_x[IW-1:0];
      ex_gen  <= s_tdata[41:10];
      ex_pay  <= s_tdata[42 +: PW];
    end
  end

  // execute: table read data is ready, decide and build the result
  logic [PW-1:0]    rd_pay;
  logic [GEN_W-1:0] rd_gen;
  logic             in_range;
  logic [IW-1:0]    slot;
  logic [XW-1:0]    slot_x;
  logic [GEN_W-1:0] new_gen;
  logic             wr_en;
  logic             push;
  logic             pop;
  logic             clr;
  logic             r_ok;
  logic             r_full;
  logic [PAY_W-1:0] r_payload;

  assign rd_pay   = tbl_rd_data[PW-1:0];
  assign rd_gen   = tbl_rd_data[DW-1:PW];
  assign in_range = (XW + 1)'(ex_idx) < (XW + 1)'(used_count);
  assign slot_x   = XW'(slot);

  always_comb begin
    slot            = '0;
    new_gen         = '0;
    wr_en           = 1'b0;
    push            = 1'b0;
    pop             = 1'b0;
    clr             = 1'b0;
    r_ok            = 1'b0;
    r_full          = 1'b0;
    r_payload       = '0;
    used_count_next = used_count;
    tbl_wr_addr     = '0;
    tbl_wr_data     = '0;
    stk_push_entry  = '0;
    unique case (ex_op)
      OP_ADD: begin
        if (ex_pay != '0) begin
          if (free_count != '0) begin
            // reuse newest freed slot; its generation travels with the stack entry
            slot    = stk_top[IW-1:0];
            new_gen = stk_top[EW-1:IW] + GEN_W'(1);
            pop     = 1'b1;
            wr_en   = 1'b1;
            r_ok    = 1'b1;
          end else if (used_count < CW'(SLOTS)) begin
            slot            = used_count[IW-1:0];
            new_gen         = '0;
            used_count_next = used_count + CW'(1);
            wr_en           = 1'b1;
            r_ok            = 1'b1;
          end else begin
            r_full = 1'b1;
          end
          tbl_wr_addr = slot;
          tbl_wr_data = {new_gen, ex_pay};
        end
      end
      OP_REMOVE: begin
        if (in_range && (rd_pay != '0)) begin
          wr_en          = 1'b1;
          tbl_wr_addr    = ex_addr;
          tbl_wr_data    = {rd_gen + GEN_W'(1), {PW{1'b0}}};
          stk_push_entry = {rd_gen + GEN_W'(1), ex_addr};
          push           = (free_count < CW'(SLOTS));
        end
      end
      OP_LOOKUP: begin
        if (in_range && (rd_pay != '0) && (rd_gen == ex_gen)) begin
          r_ok      = 1'b1;
          r_payload = PAY_W'(rd_pay);
        end
      end
      OP_CLEAR: begin
        clr             = 1'b1;
        used_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign tbl_ctrl.rd_en = accept;
  assign tbl_ctrl.wr_en = advance && wr_en;
  assign stk_ctrl.push  = advance && push;
  assign stk_ctrl.pop   = advance && pop;
  assign stk_ctrl.clear = advance && clr;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (advance) begin
      used_count <= used_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // only a successful add reports a handle
  always_ff @(posedge clk) begin
    if (advance) begin
      out_index   <= (r_ok && (ex_op == OP_ADD)) ? slot_x[IDX_W-1:0] : '0;
      out_gen     <= (r_ok && (ex_op == OP_ADD)) ? new_gen : '0;
      out_ok      <= r_ok;
      out_payload <= r_payload;
      out_full    <= r_full;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_full, out_payload, out_ok, out_gen, out_index};

  // a refused add never also reports success
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !(out_ok && out_full))
    else $error("result has both is_valid and table_full");

  // every stacked slot is a distinct appended slot
  assert property (@(posedge clk) disable iff (rst) free_count <= used_count)
    else $error("free stack deeper than appended slots");

  // an empty execute stage must always take input
  assert property (@(posedge clk) disable iff (rst) !ex_valid |-> s_tready)
    else $error("input stalled with empty execute stage");

endmodule
`default_nettype wire

/* test/slot_map_sb_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the slot allocator: shadow slot table, expected result queue and checks.
package slot_map_sb_pkg;
  import gsa_pkg::*;

  localparam int NUM_SLOTS   = 256;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [IDX_W-1:0]    slot_index;
    logic [GEN_W-1:0]    handle_gen;
    logic [PAY_W-1:0]    payload;
  } slot_op_t;

  typedef struct packed {
    logic [IDX_W-1:0] handle_index;
    logic [GEN_W-1:0] handle_generation;
    logic             is_valid;
    logic [PAY_W-1:0] payload_out;
    logic             table_full;
  } slot_result_t;

  class slot_map_scoreboard;
    bit [PAY_W-1:0] payload_tbl [NUM_SLOTS];
    bit [GEN_W-1:0] gen_tbl [NUM_SLOTS];
    bit [IDX_W-1:0] free_stk [NUM_SLOTS];
    int unsigned    free_cnt;
    int unsigned    used_cnt;
    slot_result_t   result_q [$];
    int unsigned    errors;

    function new();
      free_cnt = 0;
      used_cnt = 0;
      errors   = 0;
    endfunction

    // Apply one accepted transaction to the shadow table and queue its result.
    function void note_op(slot_op_t op);
      slot_result_t res;
      int unsigned  slot;
      bit           granted;
      res     = '0;
      slot    = 0;
      granted = 1'b0;
      case (op.opcode)
        OP_ADD: begin
          if (op.payload != '0) begin
            if (free_cnt > 0) begin
              free_cnt--;
              slot = 32'(free_stk[free_cnt]);
              gen_tbl[slot] = gen_tbl[slot] + 1'b1;
              granted = 1'b1;
            end else if (used_cnt < NUM_SLOTS) begin
              slot = used_cnt;
              used_cnt++;
              gen_tbl[slot] = '0;
              granted = 1'b1;
            end else begin
              res.table_full = 1'b1;
            end
            if (granted) begin
              payload_tbl[slot]     = op.payload;
              res.handle_index      = IDX_W'(slot);
              res.handle_generation = gen_tbl[slot];
              res.is_valid          = 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          // generation of the handle is not checked on remove
          if (op.slot_index < used_cnt && payload_tbl[op.slot_index] != '0) begin
            payload_tbl[op.slot_index] = '0;
            gen_tbl[op.slot_index]     = gen_tbl[op.slot_index] + 1'b1;
            if (free_cnt < NUM_SLOTS) begin
              free_stk[free_cnt] = op.slot_index;
              free_cnt++;
            end
          end
        end
        OP_LOOKUP: begin
          if (op.slot_index < used_cnt && payload_tbl[op.slot_index] != '0 &&
              gen_tbl[op.slot_index] == op.handle_gen) begin
            res.is_valid    = 1'b1;
            res.payload_out = payload_tbl[op.slot_index];
          end
        end
        OP_CLEAR: begin
          used_cnt = 0;
          free_cnt = 0;
        end
      endcase
      result_q = {result_q, res};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
    endtask

    task check_field(string name, logic [GEN_W-1:0] got, logic [GEN_W-1:0] want);
      if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    // Compare one result transaction against the oldest expectation.
    task check_result(logic [79:0] tdata);
      slot_result_t want;
      if (result_q.size() == 0) begin
        report($sformatf("result %h arrived with nothing expected", tdata));
        return;
      end
      want = result_q.pop_front();
      check_field("handle_index", GEN_W'(tdata[7:0]), GEN_W'(want.handle_index));
      check_field("handle_generation", tdata[39:8], want.handle_generation);
      check_field("is_valid", GEN_W'(tdata[40]), GEN_W'(want.is_valid));
      check_field("payload_out", tdata[72:41], want.payload_out);
      check_field("table_full", GEN_W'(tdata[73]), GEN_W'(want.table_full));
    endtask

    function int unsigned pending();
      return result_q.size();
    endfunction

    // Try a few random in-range slots, looking for an occupied (or free) one.
    function bit pick_slot(bit occupied, output bit [IDX_W-1:0] idx);
      idx = '0;
      if (used_cnt == 0) return 1'b0;
      for (int i = 0; i < 8; i++) begin
        idx = IDX_W'($urandom_range(0, used_cnt - 1));
        if ((payload_tbl[idx] != '0) == occupied) return 1'b1;
      end
      return 1'b0;
    endfunction
  endclass

endpackage

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Top-level testbench for the generational slot allocator core.
module tb_top;
  import gsa_pkg::*;
  import slot_map_sb_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DIRECTED_OPS = 24;
  localparam int RANDOM_OPS   = 950;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;

  bit          hold_req   = 1'b0;  // asks the ready process for one long hold-off
  bit          steady     = 1'b0;  // no idling on either side
  int unsigned burst_left = 0;     // sender transactions still sent back to back
  int unsigned cycle_cnt  = 0;
  int unsigned item_cnt   = 0;

  slot_map_scoreboard sb = new();

  generational_slot_allocator_core #(
    .SLOTS       (NUM_SLOTS),
    .PAYLOAD_BITS(PAY_W)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result monitor: every accepted result transaction is checked in order.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Receiver: random ready pattern, steady stretches and one long hold-off.
  initial begin : rx_ready
    int unsigned r;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          if ($urandom_range(0, 99) < 85) repeat ($urandom_range(1, 3)) @(posedge clk);
          else repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  function automatic slot_op_t make_op(logic [OPCODE_W-1:0] opcode, logic [IDX_W-1:0] idx,
                                       logic [GEN_W-1:0] gen, logic [PAY_W-1:0] pay);
    slot_op_t op;
    op.opcode     = opcode;
    op.slot_index = idx;
    op.handle_gen = gen;
    op.payload    = pay;
    return op;
  endfunction

  // Mostly random tags, with zero, all ones and single-bit tags mixed in.
  function automatic logic [PAY_W-1:0] rand_payload();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 20) return PAY_W'(1) << $urandom_range(0, PAY_W - 1);
    return $urandom;
  endfunction

  function automatic logic [PAY_W-1:0] nonzero_payload();
    logic [PAY_W-1:0] p;
    p = rand_payload();
    return (p == '0) ? PAY_W'(1) : p;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady || burst_left > 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IDX_W-1:0] rand_idx();
    return IDX_W'($urandom_range(0, 255));
  endfunction

  // Offer one transaction, wait for the handshake, then idle for a random gap.
  task automatic send_op(slot_op_t op);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, op.payload, op.handle_gen, op.slot_index, op.opcode};
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_op(op);
    item_cnt++;
    gap = pick_gap();
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Random operation shaped by the shadow table: lookups and removes mostly
  // hit live handles so that the reuse and generation paths get exercised.
  function automatic slot_op_t random_op();
    int unsigned      r;
    int unsigned      k;
    bit [IDX_W-1:0]   idx;
    bit               found;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    if (r < 35) begin
      return make_op(OP_ADD, rand_idx(), $urandom, rand_payload());
    end else if (r < 60) begin
      found = sb.pick_slot(1'b1, idx);
      if (found && k < 70) return make_op(OP_LOOKUP, idx, sb.gen_tbl[idx], $urandom);
      if (found && k < 85)
        return make_op(OP_LOOKUP, idx, sb.gen_tbl[idx] ^ (32'd1 << $urandom_range(0, 31)),
                       $urandom);
      // freed slot, current generation: must still miss
      if (k < 92 && sb.pick_slot(1'b0, idx))
        return make_op(OP_LOOKUP, idx, sb.gen_tbl[idx], $urandom);
      return make_op(OP_LOOKUP, rand_idx(), $urandom, $urandom);
    end else if (r < 85) begin
      found = sb.pick_slot(1'b1, idx);
      if (found && k < 75) return make_op(OP_REMOVE, idx, $urandom, $urandom);
      return make_op(OP_REMOVE, rand_idx(), $urandom, $urandom);
    end else if (r < 87) begin
      return make_op(OP_CLEAR, rand_idx(), $urandom, $urandom);
    end
    return make_op(OPCODE_W'($urandom_range(0, 3)), rand_idx(), $urandom, $urandom);
  endfunction

  // Add until no slot is left, then probe the full table.
  task automatic fill_table();
    while (!(sb.used_cnt == NUM_SLOTS && sb.free_cnt == 0))
      send_op(make_op(OP_ADD, rand_idx(), $urandom, nonzero_payload()));
    send_op(make_op(OP_ADD, rand_idx(), $urandom, nonzero_payload()));
    send_op(make_op(OP_ADD, rand_idx(), $urandom, '1));
    // zero tag wins over full: refused without the full flag
    send_op(make_op(OP_ADD, rand_idx(), $urandom, '0));
    send_op(make_op(OP_REMOVE, rand_idx(), $urandom, $urandom));
    send_op(make_op(OP_ADD, rand_idx(), $urandom, nonzero_payload()));
    send_op(make_op(OP_ADD, rand_idx(), $urandom, nonzero_payload()));
  endtask

  initial begin : stimulus
    bit hold_done;
    bit pause_done;
    bit fill1_done;
    bit fill2_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    fill1_done = 1'b0;
    fill2_done = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, refused and ignored operations, LIFO reuse, clear.
    // Generation wrap is out of reach here (needs about 2^31 reuse rounds).
    send_op(make_op(OP_LOOKUP, 8'd0, 32'd0, 32'd0));
    send_op(make_op(OP_REMOVE, 8'hFF, 32'd0, 32'd0));           // out of range
    send_op(make_op(OP_ADD, 8'd0, 32'd0, 32'd0));               // zero tag refused
    send_op(make_op(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_op(make_op(OP_ADD, 8'd0, 32'd0, 32'd1));
    send_op(make_op(OP_LOOKUP, 8'd0, 32'd0, 32'd0));
    send_op(make_op(OP_LOOKUP, 8'd0, 32'hFFFF_FFFF, 32'd0));    // generation mismatch
    send_op(make_op(OP_LOOKUP, 8'd1, 32'd0, 32'hFFFF_FFFF));
    send_op(make_op(OP_REMOVE, 8'd0, 32'hFFFF_FFFF, 32'd0));    // generation ignored
    send_op(make_op(OP_REMOVE, 8'd0, 32'd0, 32'd0));            // already empty
    send_op(make_op(OP_LOOKUP, 8'd0, 32'd1, 32'd0));            // empty slot
    send_op(make_op(OP_REMOVE, 8'd2, 32'd0, 32'd0));            // past used count
    send_op(make_op(OP_ADD, 8'd0, 32'd0, 32'hA5A5_A5A5));       // reuse slot 0
    send_op(make_op(OP_LOOKUP, 8'd0, 32'd2, 32'd0));
    send_op(make_op(OP_REMOVE, 8'd1, 32'd0, 32'd0));
    send_op(make_op(OP_REMOVE, 8'd0, 32'd0, 32'd0));
    send_op(make_op(OP_ADD, 8'd0, 32'd0, 32'h5A5A_5A5A));       // last freed first
    send_op(make_op(OP_ADD, 8'd0, 32'd0, 32'h8000_0000));
    send_op(make_op(OP_LOOKUP, 8'd1, 32'd2, 32'd0));
    send_op(make_op(OP_CLEAR, 8'd0, 32'd0, 32'd0));
    send_op(make_op(OP_LOOKUP, 8'd0, 32'd3, 32'd0));            // gone after clear
    send_op(make_op(OP_REMOVE, 8'd0, 32'd0, 32'd0));
    send_op(make_op(OP_ADD, 8'd0, 32'd0, 32'h1234_5678));       // fresh slot, gen 0
    send_op(make_op(OP_LOOKUP, 8'd0, 32'd0, 32'd0));

    while (item_cnt < DIRECTED_OPS + RANDOM_OPS) begin
      if (!hold_done && item_cnt >= 150) begin
        // receiver stalls while the sender keeps pushing: input must back up
        hold_done  = 1'b1;
        hold_req   = 1'b1;
        burst_left = 60;
      end
      if (!fill1_done && item_cnt >= 300) begin
        fill1_done = 1'b1;
        fill_table();
      end
      if (!pause_done && item_cnt >= 500) begin
        pause_done = 1'b1;
        s_tvalid <= 1'b0;
        drain_results();
        @(posedge clk);
      end
      if (!fill2_done && item_cnt >= 700) begin
        fill2_done = 1'b1;
        fill_table();
      end
      steady = (item_cnt >= 1180 && item_cnt < 1260);
      send_op(random_op());
    end
    steady = 1'b0;

    s_tvalid <= 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
